FILE: src/apa_pkg.sv
// ----------------------------------------------------------------------------
// Anemometer period averager package
// Shared widths, register indexes, reset values and item codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package apa_pkg;

    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 16;
    localparam int CALM_W   = 8;
    localparam int UNIT_W   = 16;
    localparam int PERIOD_W = 16;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE_US  = 2'd0,
        REG_CALM_TIMEOUT = 2'd1,
        REG_MAX_SUM_US   = 2'd2,
        REG_UNIT_US      = 2'd3
    } cfg_index_t;

    typedef enum logic {
        MODE_PULSE  = 1'b0,
        MODE_REPORT = 1'b1
    } mode_t;

    localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 32'd10000;
    localparam logic [CALM_W-1:0] CALM_RESET     = 8'd30;
    localparam logic [TIME_W-1:0] MAX_SUM_RESET  = 32'd6000000;
    localparam logic [UNIT_W-1:0] UNIT_RESET     = 16'd100;

endpackage

FILE: src/apa_in_if.sv
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying pulse and report words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface apa_in_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [apa_pkg::TIME_W-1:0]  timestamp_us;

    modport source (output valid, output mode, output timestamp_us, input ready);
    modport sink   (input valid, input mode, input timestamp_us, output ready);
endinterface

FILE: src/apa_out_if.sv
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel carrying one result word per report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface apa_out_if;
    logic                          valid;
    logic                          ready;
    logic [apa_pkg::PERIOD_W-1:0]  rotation_period;
    logic [apa_pkg::COUNT_W-1:0]   pulses_in_interval;

    modport source (output valid, output rotation_period, output pulses_in_interval,
                    input ready);
    modport sink   (input valid, input rotation_period, input pulses_in_interval,
                    output ready);
endinterface

FILE: src/apa_divider.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apa_divider
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [apa_pkg::TIME_W-1:0] dividend,
    input  logic [apa_pkg::TIME_W-1:0] divisor,
    output logic                       done,
    output logic [apa_pkg::TIME_W-1:0] quotient
);
    import apa_pkg::*;

    localparam int STEP_W = $clog2(TIME_W);

    typedef enum logic {
        D_IDLE,
        D_RUN
    } div_state_t;

    div_state_t          state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [TIME_W:0]     rem_reg;
    logic [TIME_W-1:0]   quot_reg;
    logic [TIME_W-1:0]   dvs_reg;
    logic                done_reg;

    logic [TIME_W:0]     rem_shift;
    logic [TIME_W:0]     rem_diff;
    logic                fits;

    // The dividend is shifted out of the quotient register into the remainder.
    assign rem_shift = {rem_reg[TIME_W-1:0], quot_reg[TIME_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};
    assign fits      = ~rem_diff[TIME_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
            rem_reg   <= '0;
            quot_reg  <= '0;
            dvs_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        rem_reg   <= '0;
                        quot_reg  <= dividend;
                        dvs_reg   <= divisor;
                        step_reg  <= '0;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    rem_reg  <= fits ? rem_diff : rem_shift;
                    quot_reg <= {quot_reg[TIME_W-2:0], fits};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(TIME_W - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

FILE: src/anemometer_pulse_period_averager.sv
// ----------------------------------------------------------------------------
// Anemometer pulse period averager
// Debounces timestamped cup pulses and reports the average rotation period.
// ----------------------------------------------------------------------------
// The input channel takes two kinds of word. A pulse word (mode 0) carries a
// microsecond timestamp; it is counted when the wrapping gap since the last
// counted pulse exceeds debounce_us, and it produces no result. A report word
// (mode 1) takes the gap sum and pulse count, clears them and produces one
// result word with the held period and the pulse count.
// A pulse word leaves the block idle, so pulses may follow back to back. A
// report that updates the period runs a 16x16 multiply (multiply state) and a
// restoring division through the divider (division state), one quotient bit
// per cycle; its result word is then presented from the output state, and the
// next word can be taken once the block is back in idle. Any other report
// goes from acceptance straight to the output state.
// The block takes no word while a report is being worked on.
// The result sits in an output register; pulses are still taken while it
// waits, and a finished report waits in place until the register is free.
// Reset clears all state and loads the register defaults; the configuration
// port writes one register per cycle and should be used while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module anemometer_pulse_period_averager
(
    input  logic                          clk,
    input  logic                          rst_n,
    apa_in_if.sink                        in_ch,
    apa_out_if.source                     out_ch,
    input  logic                          cfg_we,
    input  logic [apa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [apa_pkg::CFG_W-1:0]     cfg_data
);
    import apa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_OUT
    } state_t;

    state_t               state_reg;

    logic [TIME_W-1:0]    debounce_reg;
    logic [CALM_W-1:0]    calm_timeout_reg;
    logic [TIME_W-1:0]    max_sum_reg;
    logic [UNIT_W-1:0]    unit_reg;

    logic [TIME_W-1:0]    last_edge_reg;
    logic [TIME_W-1:0]    gap_sum_reg;
    logic [COUNT_W-1:0]   pulse_count_reg;
    logic [CALM_W-1:0]    calm_count_reg;
    logic [PERIOD_W-1:0]  held_period_reg;

    logic [TIME_W-1:0]    sum_reg;
    logic [COUNT_W-1:0]   cnt_reg;
    logic [TIME_W-1:0]    prod_reg;
    logic                 div_start_reg;

    logic                 out_valid_reg;
    logic [PERIOD_W-1:0]  out_period_reg;
    logic [COUNT_W-1:0]   out_count_reg;

    logic                 in_fire;
    logic [TIME_W-1:0]    gap_next;
    logic                 pulse_ok;
    logic                 do_divide;
    logic [UNIT_W-1:0]    unit_eff;
    logic                 out_free;
    logic                 div_done;
    logic [TIME_W-1:0]    div_quot;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign gap_next    = in_ch.timestamp_us - last_edge_reg;
    assign pulse_ok    = gap_next > debounce_reg;
    assign do_divide   = (pulse_count_reg != '0) && (calm_count_reg != calm_timeout_reg)
                         && (gap_sum_reg < max_sum_reg);
    assign unit_eff    = (unit_reg == '0) ? UNIT_W'(1) : unit_reg;
    assign out_free    = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg     <= DEBOUNCE_RESET;
            calm_timeout_reg <= CALM_RESET;
            max_sum_reg      <= MAX_SUM_RESET;
            unit_reg         <= UNIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_DEBOUNCE_US:  debounce_reg     <= cfg_data;
                REG_CALM_TIMEOUT: calm_timeout_reg <= cfg_data[CALM_W-1:0];
                REG_MAX_SUM_US:   max_sum_reg      <= cfg_data;
                REG_UNIT_US:      unit_reg         <= cfg_data[UNIT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            last_edge_reg   <= '0;
            gap_sum_reg     <= '0;
            pulse_count_reg <= '0;
            calm_count_reg  <= '0;
            held_period_reg <= '0;
            sum_reg         <= '0;
            cnt_reg         <= '0;
            prod_reg        <= '0;
            div_start_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_period_reg  <= '0;
            out_count_reg   <= '0;
        end
        else
        begin
            div_start_reg <= (state_reg == S_MUL);
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && (in_ch.mode == MODE_PULSE))
                    begin
                        if (pulse_ok)
                        begin
                            last_edge_reg   <= in_ch.timestamp_us;
                            gap_sum_reg     <= gap_sum_reg + gap_next;
                            pulse_count_reg <= pulse_count_reg + 1'b1;
                        end
                    end
                    else if (in_fire)
                    begin
                        sum_reg         <= gap_sum_reg;
                        cnt_reg         <= pulse_count_reg;
                        gap_sum_reg     <= '0;
                        pulse_count_reg <= '0;
                        if (pulse_count_reg != '0)
                        begin
                            calm_count_reg <= '0;
                        end
                        else if (calm_count_reg < calm_timeout_reg)
                        begin
                            calm_count_reg <= calm_count_reg + 1'b1;
                        end
                        else
                        begin
                            held_period_reg <= '0;
                        end
                        state_reg <= do_divide ? S_MUL : S_OUT;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= TIME_W'(unit_eff) * TIME_W'(cnt_reg);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        // Quotients that do not fit the period field saturate.
                        held_period_reg <= (div_quot[TIME_W-1:PERIOD_W] != '0)
                                           ? '1 : div_quot[PERIOD_W-1:0];
                        state_reg       <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_period_reg <= held_period_reg;
                        out_count_reg  <= cnt_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    apa_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (sum_reg),
        .divisor  (prod_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.rotation_period    = out_period_reg;
    assign out_ch.pulses_in_interval = out_count_reg;

endmodule

FILE: tb/sv/apa_period_checker.sv
// ----------------------------------------------------------------------------
// Anemometer period averager checker
// Watches the input, output and configuration ports of the averager, keeps its
// own copy of the debounce, gap sum, pulse count, calm count and held period,
// and compares every result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apa_period_checker
    import apa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    apa_in_if                    in_ch,
    apa_out_if                   out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   expected_left
);

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [COUNT_W-1:0]  pulses;
    } report_word_t;

    report_word_t expected_reports[$];

    logic [TIME_W-1:0]   debounce_cfg;
    logic [CALM_W-1:0]   calm_limit_cfg;
    logic [TIME_W-1:0]   max_sum_cfg;
    logic [UNIT_W-1:0]   unit_cfg;

    logic [TIME_W-1:0]   last_edge;
    logic [TIME_W-1:0]   gap_acc;
    logic [COUNT_W-1:0]  pulse_tally;
    logic [CALM_W-1:0]   calm_tally;
    logic [PERIOD_W-1:0] held_period;

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    // Advances the averager state by one accepted input word and queues the
    // result word that a report produces.
    task automatic track_word(input mode_t kind, input logic [TIME_W-1:0] stamp);
        logic [TIME_W-1:0]  gap;
        logic [TIME_W-1:0]  sum;
        logic [COUNT_W-1:0] cnt;
        logic [63:0]        divisor;
        logic [63:0]        quot;
        report_word_t       word;
        if (kind == MODE_PULSE)
        begin
            gap = stamp - last_edge;
            if (gap > debounce_cfg)
            begin
                last_edge   = stamp;
                gap_acc     = gap_acc + gap;
                pulse_tally = pulse_tally + 1'b1;
            end
        end
        else
        begin
            sum         = gap_acc;
            cnt         = pulse_tally;
            gap_acc     = '0;
            pulse_tally = '0;
            if (cnt != '0)
            begin
                // The first report with pulses after a calm leaves the period alone.
                if (calm_tally != calm_limit_cfg && sum < max_sum_cfg)
                begin
                    divisor = ((unit_cfg == '0) ? 64'd1 : 64'(unit_cfg)) * 64'(cnt);
                    quot    = 64'(sum) / divisor;
                    held_period = (quot > 64'hFFFF) ? '1 : quot[PERIOD_W-1:0];
                end
                calm_tally = '0;
            end
            else if (calm_tally < calm_limit_cfg)
            begin
                calm_tally = calm_tally + 1'b1;
            end
            else
            begin
                held_period = '0;
            end
            word.period = held_period;
            word.pulses = cnt;
            expected_reports.push_back(word);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        report_word_t got;
        report_word_t want;
        if (!rst_n)
        begin
            debounce_cfg   = DEBOUNCE_RESET;
            calm_limit_cfg = CALM_RESET;
            max_sum_cfg    = MAX_SUM_RESET;
            unit_cfg       = UNIT_RESET;
            last_edge      = '0;
            gap_acc        = '0;
            pulse_tally    = '0;
            calm_tally     = '0;
            held_period    = '0;
            expected_reports.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    REG_DEBOUNCE_US:  debounce_cfg   = cfg_data[TIME_W-1:0];
                    REG_CALM_TIMEOUT: calm_limit_cfg = cfg_data[CALM_W-1:0];
                    REG_MAX_SUM_US:   max_sum_cfg    = cfg_data[TIME_W-1:0];
                    REG_UNIT_US:      unit_cfg       = cfg_data[UNIT_W-1:0];
                    default:          ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
            begin
                track_word(mode_t'(in_ch.mode), in_ch.timestamp_us);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got.period = out_ch.rotation_period;
                got.pulses = out_ch.pulses_in_interval;
                if (expected_reports.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result word period %0d pulses %0d",
                                              got.period, got.pulses));
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got.period !== want.period)
                    begin
                        report_mismatch($sformatf("rotation_period %0d, expected %0d",
                                                  got.period, want.period));
                    end
                    if (got.pulses !== want.pulses)
                    begin
                        report_mismatch($sformatf("pulses_in_interval %0d, expected %0d",
                                                  got.pulses, want.pulses));
                    end
                end
            end
        end
        expected_left = expected_reports.size();
    end

endmodule

FILE: tb/sv/tb_anemometer_pulse_period_averager.sv
// ----------------------------------------------------------------------------
// Anemometer period averager testbench
// Drives directed and random pulse and report words through the averager
// under several register settings, with random stalls on both channels, and
// gives the verdict from the failure count of the checker beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_anemometer_pulse_period_averager;
    import apa_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 7;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int PRESSURE_CYCLES = 400;
    localparam int RANDOM_PHASES   = 5;
    localparam int WORDS_PER_PHASE = 140;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    int fail_count;
    int expected_left;
    int cycle_count = 0;

    bit quiet        = 1'b0;
    bit hold_request = 1'b0;

    logic [TIME_W-1:0] now_us;
    logic [TIME_W-1:0] debounce_sel;
    logic [CALM_W-1:0] calm_sel;

    apa_in_if  in_ch();
    apa_out_if out_ch();

    anemometer_pulse_period_averager dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    apa_period_checker period_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    always #(HALF_PERIOD) clk = ~clk;

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off so that the
    // output register and then the input fill up.
    initial
    begin
        int stall;
        bit hold_done;
        stall     = 0;
        hold_done = 1'b0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(negedge clk);
            end
            if (stall == 0 && !quiet && rst_n && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 9);
            end
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input mode_t kind, input logic [TIME_W-1:0] stamp);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= kind;
        in_ch.timestamp_us <= stamp;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
    endtask

    // Pulses never give a result, so the last one may still be in flight when
    // the final report word has come back.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (expected_left != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_settings(input logic [TIME_W-1:0] deb, input logic [CALM_W-1:0] calm,
                                 input logic [TIME_W-1:0] sum_limit,
                                 input logic [UNIT_W-1:0] unit_val);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEBOUNCE_US;
        cfg_data  <= deb;
        @(negedge clk);
        cfg_index <= REG_CALM_TIMEOUT;
        cfg_data  <= CFG_W'(calm);
        @(negedge clk);
        cfg_index <= REG_MAX_SUM_US;
        cfg_data  <= sum_limit;
        @(negedge clk);
        cfg_index <= REG_UNIT_US;
        cfg_data  <= CFG_W'(unit_val);
        @(negedge clk);
        cfg_we <= 1'b0;
        debounce_sel = deb;
        calm_sel     = calm;
    endtask

    initial
    begin
        int          words;
        int          burst;
        int          pick;
        int          calm_run;
        int unsigned span_max;
        logic [TIME_W-1:0] deb;
        logic [CALM_W-1:0] calm;
        logic [TIME_W-1:0] sum_limit;
        logic [UNIT_W-1:0] unit_val;

        in_ch.valid        = 1'b0;
        in_ch.mode         = MODE_PULSE;
        in_ch.timestamp_us = '0;
        debounce_sel       = DEBOUNCE_RESET;
        calm_sel           = CALM_RESET;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings. The first gap is measured from time zero, and a gap
        // equal to the debounce time is still a bounce.
        send_word(MODE_PULSE, 32'd5000);
        send_word(MODE_PULSE, 32'd10000);
        send_word(MODE_PULSE, 32'd10001);
        send_word(MODE_PULSE, 32'd15000);
        send_word(MODE_PULSE, 32'd30001);
        send_word(MODE_REPORT, 32'hFFFF_FFFF);
        send_word(MODE_REPORT, 32'd0);
        // A gap across the wrap of the timestamp, and a sum over the limit.
        send_word(MODE_PULSE, 32'hFFFF_FFF0);
        send_word(MODE_PULSE, 32'h0001_0000);
        send_word(MODE_REPORT, 32'h5555_AAAA);

        // Zero unit, zero debounce: saturated quotient, then calm handling.
        load_settings(32'd0, 8'd2, 32'hFFFF_FFFF, 16'd0);
        now_us = 32'h0001_0000;
        send_word(MODE_PULSE, now_us);
        now_us = now_us + 32'd200000;
        send_word(MODE_PULSE, now_us);
        send_word(MODE_REPORT, 32'd0);
        repeat (3) send_word(MODE_REPORT, 32'd0);
        now_us = now_us + 32'd1000;
        send_word(MODE_PULSE, now_us);
        send_word(MODE_REPORT, 32'd0);
        now_us = now_us + 32'd1000;
        send_word(MODE_PULSE, now_us);
        send_word(MODE_REPORT, 32'd0);
        repeat (2) send_word(MODE_REPORT, 32'd0);

        // The calm count now sits above a timeout lowered to zero.
        load_settings(32'd0, 8'd0, 32'hFFFF_FFFF, 16'hFFFF);
        now_us = now_us + 32'd196605;
        send_word(MODE_PULSE, now_us);
        send_word(MODE_REPORT, 32'd0);
        send_word(MODE_REPORT, 32'd0);
        now_us = now_us + 32'd70000;
        send_word(MODE_PULSE, now_us);
        send_word(MODE_REPORT, 32'd0);

        // Largest debounce: no pulse can ever pass.
        load_settings(32'hFFFF_FFFF, 8'hFF, 32'd0, 16'hFFFF);
        send_word(MODE_PULSE, 32'd0);
        send_word(MODE_PULSE, 32'hFFFF_FFFF);
        send_word(MODE_REPORT, 32'd0);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 3))
                0:       deb = '0;
                1:       deb = $urandom_range(1, 20000);
                2:       deb = DEBOUNCE_RESET;
                default: deb = $urandom();
            endcase
            case ($urandom_range(0, 2))
                0:       calm = CALM_W'($urandom_range(0, 3));
                1:       calm = CALM_RESET;
                default: calm = CALM_W'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 3))
                0:       sum_limit = $urandom();
                1:       sum_limit = MAX_SUM_RESET;
                2:       sum_limit = 32'hFFFF_FFFF;
                default: sum_limit = $urandom_range(0, 2000000);
            endcase
            case ($urandom_range(0, 3))
                0:       unit_val = '0;
                1:       unit_val = UNIT_W'($urandom_range(1, 200));
                2:       unit_val = UNIT_RESET;
                default: unit_val = UNIT_W'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 2))
                0:       span_max = 2000;
                1:       span_max = 100000;
                default: span_max = 2000000;
            endcase
            load_settings(deb, calm, sum_limit, unit_val);
            if (phase == 1)
                hold_request = 1'b1;
            if (phase == RANDOM_PHASES - 1)
                quiet = 1'b1;

            // Mostly clean rotations between reports, with bounces, stray
            // timestamps and runs of calm reports mixed in.
            words = 0;
            while (words < WORDS_PER_PHASE)
            begin
                burst = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                repeat (burst)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 7)
                        now_us = now_us + debounce_sel + 1'b1 + $urandom_range(0, span_max);
                    else if (pick < 9)
                        now_us = now_us + $urandom_range(0, debounce_sel);
                    else
                        now_us = $urandom();
                    send_word(MODE_PULSE, now_us);
                    words++;
                end
                calm_run = 1;
                if ($urandom_range(0, 7) == 0)
                    calm_run = (calm_sel <= 40) ? calm_sel + 2 : $urandom_range(2, 10);
                repeat (calm_run)
                begin
                    send_word(MODE_REPORT, $urandom());
                    words++;
                end
            end
        end

        settle();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
src/apa_pkg.sv
src/apa_in_if.sv
src/apa_out_if.sv
src/apa_divider.sv
src/anemometer_pulse_period_averager.sv
tb/sv/apa_period_checker.sv
tb/sv/tb_anemometer_pulse_period_averager.sv
